### rtl/spcc_pkg.sv
`timescale 1ns / 1ps
// Package for the speed PID current command unit.
// Widths, reset values and register indexes; no dependencies.
package spcc_pkg;

  // Gains are unsigned fixed point with this many fraction bits.
  localparam int GainFracBits = 8;

  localparam int RpmW   = 16;             // input speed fields
  localparam int GainW  = 16;             // gain registers
  localparam int LimW   = 15;             // limit registers
  localparam int CurW   = 16;             // drive current
  localparam int ErrW   = RpmW + 1;       // target - measured
  localparam int DerW   = ErrW + 1;       // error - previous error, also I + e
  localparam int IntW   = 16;             // integral, updated only strictly inside +/- limit
  localparam int PpW    = GainW + 1 + ErrW;
  localparam int PiW    = GainW + 1 + IntW;
  localparam int PdW    = GainW + 1 + DerW;
  localparam int AccW   = PdW;            // sum of the three fits this width
  localparam int QuoW   = AccW - GainFracBits;
  localparam int CfgIdxW = 3;

  localparam logic [GainW-1:0] KpReset   = GainW'(666);
  localparam logic [GainW-1:0] KiReset   = GainW'(205);
  localparam logic [GainW-1:0] KdReset   = GainW'(205);
  localparam logic [LimW-1:0]  IlimReset = LimW'(600);
  localparam logic [LimW-1:0]  OlimReset = LimW'(10000);

  typedef enum logic [CfgIdxW-1:0] {
    CfgKp   = 3'd0,
    CfgKi   = 3'd1,
    CfgKd   = 3'd2,
    CfgIlim = 3'd3,
    CfgOlim = 3'd4
  } cfg_idx_e;

endpackage

### rtl/spcc_if.sv
`timescale 1ns / 1ps
// Valid/ready channels of the speed PID current command unit.
// Depends on spcc_pkg for the field widths.
interface spcc_cmd_if;
  import spcc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [RpmW-1:0] target_rpm;
  logic signed [RpmW-1:0] measured_rpm;

  modport source (output valid, output target_rpm, output measured_rpm, input ready);
  modport sink   (input valid, input target_rpm, input measured_rpm, output ready);
endinterface

interface spcc_cur_if;
  import spcc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [CurW-1:0] drive_current;
  logic                   clamped;

  modport source (output valid, output drive_current, output clamped, input ready);
  modport sink   (input valid, input drive_current, input clamped, output ready);
endinterface

### rtl/speed_pid_current_command_unit.sv
`timescale 1ns / 1ps
// Speed-loop PID producing a clamped motor current command.
// Depends on spcc_pkg and the channel interfaces in spcc_if.sv.

// One command word in, one current word out. The unit takes a word every
// cycle unless a stalled output has filled the pipe. Speed error is registered at the
// input, then derivative and conditional integral update, then the three
// gain products, then sum, truncating divide by 2^8 and clamp into the output
// register. Throughput is set by the integral/previous-error update in stage
// two, whose feedback loop closes within that stage's own registers. Every
// stage has its own valid bit and moves whenever the stage after it is empty
// or moving, so a stalled output word does not stop a word being accepted
// while bubbles remain. The user must write gains and limits through the cfg
// port only while no word is in flight; the unit does not enforce this.
// Out-of-range indexes are ignored.
module speed_pid_current_command_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [spcc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [spcc_pkg::GainW-1:0]    cfg_wdata_i,
  spcc_cmd_if.sink                      cmd_i,
  spcc_cur_if.source                    cur_o
);
  import spcc_pkg::*;

  // Configuration registers
  logic [GainW-1:0] kp_q, ki_q, kd_q;
  logic [LimW-1:0]  ilim_q, olim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= KpReset;
      ki_q   <= KiReset;
      kd_q   <= KdReset;
      ilim_q <= IlimReset;
      olim_q <= OlimReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgKp:   kp_q   <= cfg_wdata_i;
        CfgKi:   ki_q   <= cfg_wdata_i;
        CfgKd:   kd_q   <= cfg_wdata_i;
        CfgIlim: ilim_q <= cfg_wdata_i[LimW-1:0];
        CfgOlim: olim_q <= cfg_wdata_i[LimW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // Stage flow control: a stage loads when it is empty or its word leaves.
  logic v1_q, v2_q, v3_q, vo_q;
  logic rdy1, rdy2, rdy3, rdyo;

  assign rdyo = !vo_q || cur_o.ready;
  assign rdy3 = !v3_q || rdyo;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign cmd_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= cmd_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdyo) vo_q <= v3_q;
    end
  end

  // Stage 1: speed error
  logic signed [ErrW-1:0] err1_d, err1_q;

  assign err1_d = ErrW'(cmd_i.target_rpm) - ErrW'(cmd_i.measured_rpm);

  always_ff @(posedge clk_i) begin
    if (rdy1 && cmd_i.valid) err1_q <= err1_d;
  end

  // Stage 2: derivative and conditional integration (anti-windup)
  logic signed [ErrW-1:0] prev_err_q;
  logic signed [IntW-1:0] integ_q, integ_d;
  logic signed [DerW-1:0] der2_d, trial;
  logic        [DerW-1:0] trial_mag;
  logic                   take;
  logic signed [ErrW-1:0] err2_q;
  logic signed [DerW-1:0] der2_q;
  logic signed [IntW-1:0] int2_q;

  assign der2_d    = DerW'(err1_q) - DerW'(prev_err_q);
  assign trial     = DerW'(integ_q) + DerW'(err1_q);
  assign trial_mag = trial[DerW-1] ? DerW'(-trial) : DerW'(trial);
  // strict compare: hitting the limit exactly is refused
  assign take      = trial_mag < DerW'(ilim_q);
  assign integ_d   = take ? trial[IntW-1:0] : integ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      integ_q    <= '0;
    end else if (rdy2 && v1_q) begin
      prev_err_q <= err1_q;
      integ_q    <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      err2_q <= err1_q;
      der2_q <= der2_d;
      int2_q <= integ_d;
    end
  end

  // Stage 3: gain products, gains zero-extended to signed
  logic signed [GainW:0]  kp_s, ki_s, kd_s;
  logic signed [PpW-1:0]  pp_q;
  logic signed [PiW-1:0]  pi_q;
  logic signed [PdW-1:0]  pd_q;

  assign kp_s = $signed({1'b0, kp_q});
  assign ki_s = $signed({1'b0, ki_q});
  assign kd_s = $signed({1'b0, kd_q});

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      pp_q <= PpW'(kp_s) * PpW'(err2_q);
      pi_q <= PiW'(ki_s) * PiW'(int2_q);
      pd_q <= PdW'(kd_s) * PdW'(der2_q);
    end
  end

  // Output stage: sum, divide toward zero, symmetric clamp
  localparam logic [AccW-1:0] DivBias = AccW'((1 << GainFracBits) - 1);

  logic signed [AccW-1:0] acc, acc_biased;
  logic signed [QuoW-1:0] quo, lim_pos, lim_neg;
  logic signed [CurW-1:0] cur_d, cur_q;
  logic                   clamp_d, clamp_q;

  assign acc        = AccW'(pp_q) + AccW'(pi_q) + AccW'(pd_q);
  // add 2^F-1 on negatives so the arithmetic shift rounds toward zero
  assign acc_biased = acc + (acc[AccW-1] ? $signed(DivBias) : $signed(AccW'(0)));
  assign quo        = $signed(acc_biased[AccW-1:GainFracBits]);
  assign lim_pos    = $signed(QuoW'(olim_q));
  assign lim_neg    = -lim_pos;

  always_comb begin
    priority if (quo > lim_pos) begin
      cur_d   = CurW'(lim_pos);
      clamp_d = 1'b1;
    end else if (quo < lim_neg) begin
      cur_d   = CurW'(lim_neg);
      clamp_d = 1'b1;
    end else begin
      cur_d   = quo[CurW-1:0];
      clamp_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdyo && v3_q) begin
      cur_q   <= cur_d;
      clamp_q <= clamp_d;
    end
  end

  assign cur_o.valid         = vo_q;
  assign cur_o.drive_current = cur_q;
  assign cur_o.clamped       = clamp_q;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for speed_pid_current_command_unit: directed and random command words,
// each current word checked against a PID predictor kept in the bench.
// Depends on spcc_pkg and the channel interfaces in spcc_if.sv.
module tb_top;
  import spcc_pkg::*;

  localparam int NumCfgRegs   = 5;      // registers behind the cfg port
  localparam int SettleCycles = 8;      // drain margin; the pipeline is four deep
  localparam int CycleLimit   = 400000; // watchdog, far above the slowest legal run
  localparam int RandomWords  = 1950;   // spread over four traffic phases
  localparam int MaxReports   = 10;

  // One expected current word.
  typedef struct {
    logic signed [CurW-1:0] drive_current;
    logic                   clamped;
  } cur_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [GainW-1:0]    cfg_wdata_i;

  spcc_cmd_if cmd_if ();
  spcc_cur_if cur_if ();

  speed_pid_current_command_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_if),
    .cur_o       (cur_if)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // PID predictor: bench copy of gains, limits and loop state.
  // ---------------------------------------------------------------------------
  logic [GainW-1:0]       kp_gain, ki_gain, kd_gain;
  logic [LimW-1:0]        int_limit, out_limit;
  logic signed [DerW-1:0] last_error;   // error of the previous word
  logic signed [IntW-1:0] int_sum;      // updated only while strictly inside +/- int_limit

  cur_word_t expected_currents[$];      // predicted words, oldest first

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int mismatches    = 0;
  int cycle_count;

  int rpm_corners[5] = '{-32768, -1, 0, 1, 32767};

  // Computes the current word for one command and advances the loop state.
  function automatic cur_word_t predict_current(input logic signed [RpmW-1:0] target,
                                                input logic signed [RpmW-1:0] measured);
    logic signed [ErrW-1:0] speed_err;
    logic signed [DerW-1:0] deriv, trial, mag;
    longint                 acc, quo, lim;
    cur_word_t              w;
    speed_err = target - measured;
    deriv     = speed_err - last_error;
    trial     = int_sum + speed_err;
    mag       = (trial < 0) ? -trial : trial;
    // Conditional integration: the edge value itself is refused.
    if (int'(mag) < int'(int_limit)) int_sum = IntW'(trial);
    acc = longint'(kp_gain) * longint'(speed_err)
        + longint'(ki_gain) * longint'(int_sum)
        + longint'(kd_gain) * longint'(deriv);
    quo = acc / (longint'(1) << GainFracBits);   // truncates toward zero
    last_error = speed_err;
    lim = longint'(out_limit);
    w.clamped = 1'b1;
    if (quo > lim) quo = lim;
    else if (quo < -lim) quo = -lim;
    else w.clamped = 1'b0;
    w.drive_current = CurW'(quo);
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel and register helpers
  // ---------------------------------------------------------------------------

  // One register write; the port has no handshake so one cycle of enable is it.
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [GainW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    unique case (idx)
      CfgKp:   kp_gain   = data;
      CfgKi:   ki_gain   = data;
      CfgKd:   kd_gain   = data;
      CfgIlim: int_limit = data[LimW-1:0];
      CfgOlim: out_limit = data[LimW-1:0];
      default: ;   // unused index, write dropped
    endcase
  endtask

  // Sends one command word. Entered right at a clock edge; returns at the
  // edge where the word was taken, with the prediction already queued.
  task automatic send_cmd(input logic signed [RpmW-1:0] target,
                          input logic signed [RpmW-1:0] measured);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      cmd_if.valid        <= 1'b0;
      cmd_if.target_rpm   <= RpmW'($urandom);   // junk while idle
      cmd_if.measured_rpm <= RpmW'($urandom);
      @(posedge clk_i);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.target_rpm   <= target;
    cmd_if.measured_rpm <= measured;
    do @(posedge clk_i); while (!cmd_if.ready);
    expected_currents.push_back(predict_current(target, measured));
  endtask

  // Drops valid, waits for every predicted word, then lets the pipe drain.
  task automatic settle();
    cmd_if.valid <= 1'b0;
    while (expected_currents.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure and the word check.
  // Values are read right after the edge, before any flop update lands.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : current_check
    cur_word_t want;
    if (rst_ni && cur_if.valid && cur_if.ready) begin
      if (expected_currents.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: current word %0d/%0b with nothing expected", $realtime,
                   cur_if.drive_current, cur_if.clamped);
      end else begin
        want = expected_currents.pop_front();
        if (cur_if.drive_current !== want.drive_current) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: drive_current got %0d, want %0d", $realtime,
                     cur_if.drive_current, want.drive_current);
        end
        if (cur_if.clamped !== want.clamped) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: clamped got %0b, want %0b", $realtime,
                     cur_if.clamped, want.clamped);
        end
      end
    end
    cur_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset gains: zero error, full-scale errors both ways and the largest
  // derivative swing (+65535 straight to -65535).
  task automatic test_reset_defaults();
    settle();
    send_cmd(RpmW'(0), RpmW'(0));
    send_cmd(RpmW'(32767), RpmW'(-32768));
    send_cmd(RpmW'(-32768), RpmW'(32767));
    send_cmd(RpmW'(-32768), RpmW'(-32768));
    send_cmd(RpmW'(150), RpmW'(0));
  endtask

  // Integral window with v = I: Ki is 1.0, Kp and Kd off. The first word pulls
  // the integral back to zero, then it is walked to the edge of the window.
  task automatic test_integral_window();
    settle();
    cfg_write(CfgKp, '0);
    cfg_write(CfgKd, '0);
    cfg_write(CfgKi, GainW'(1 << GainFracBits));
    cfg_write(CfgOlim, GainW'(32767));
    cfg_write(CfgIlim, GainW'(10));
    send_cmd(RpmW'(-int_sum), RpmW'(0));   // trial lands on zero, taken
    send_cmd(RpmW'(4), RpmW'(0));
    send_cmd(RpmW'(5), RpmW'(0));          // I = 9
    send_cmd(RpmW'(1), RpmW'(0));          // |I + e| == limit: refused
    send_cmd(RpmW'(-19), RpmW'(0));        // -10: refused as well
    send_cmd(RpmW'(-18), RpmW'(0));        // I = -9
    settle();
    cfg_write(CfgIlim, '0);                // closed window: integral frozen
    send_cmd(RpmW'(-1), RpmW'(0));
  endtask

  // Output clamp: exact limit passes unflagged, one past it clamps; division
  // rounds toward zero on negatives; a zero limit flags any nonzero value.
  task automatic test_output_clamp();
    settle();
    cfg_write(CfgKi, '0);
    cfg_write(CfgKp, GainW'(1 << GainFracBits));
    cfg_write(CfgOlim, GainW'(100));
    send_cmd(RpmW'(100), RpmW'(0));
    send_cmd(RpmW'(101), RpmW'(0));
    send_cmd(RpmW'(-100), RpmW'(0));
    send_cmd(RpmW'(-101), RpmW'(0));
    settle();
    cfg_write(CfgKp, GainW'(1));
    send_cmd(RpmW'(-255), RpmW'(0));       // -255/256 -> 0, not -1
    send_cmd(RpmW'(-257), RpmW'(0));       // -> -1
    settle();
    cfg_write(CfgKp, GainW'(1 << GainFracBits));
    cfg_write(CfgOlim, '0);
    send_cmd(RpmW'(3), RpmW'(0));
    send_cmd(RpmW'(0), RpmW'(0));
  endtask

  // All-ones into every register (limits keep 15 bits), then zeros into the
  // unused indexes: any aliasing would wipe a live register.
  task automatic test_register_decode();
    settle();
    for (int r = 0; r < NumCfgRegs; r++) cfg_write(CfgIdxW'(r), '1);
    for (int r = NumCfgRegs; r < (1 << CfgIdxW); r++) cfg_write(CfgIdxW'(r), '0);
    send_cmd(RpmW'(32767), RpmW'(-32768));
    send_cmd(RpmW'(-32768), RpmW'(32767));
  endtask

  // Random traffic under one idling profile, two register settings per phase.
  // Mostly a setpoint with the measured speed scattered around it, so the
  // integral and the clamp both see action; the rest is corners and noise.
  task automatic test_random_traffic(input int idle_pct, input int stall);
    int                     set_rpm, spread, meas;
    logic [GainW-1:0]       val;
    logic signed [RpmW-1:0] tgt, msr;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    for (int half = 0; half < 2; half++) begin
      settle();
      for (int r = 0; r < NumCfgRegs; r++) begin
        case ($urandom_range(4))
          0:       val = '0;
          1:       val = '1;
          2:       val = GainW'($urandom_range(1023));
          default: val = GainW'($urandom);
        endcase
        cfg_write(CfgIdxW'(r), val);
      end
      if ($urandom_range(1))
        cfg_write(CfgIdxW'($urandom_range((1 << CfgIdxW) - 1, NumCfgRegs)), GainW'($urandom));
      set_rpm = int'($signed(RpmW'($urandom)));
      spread  = 64;
      for (int n = 0; n < RandomWords / 8; n++) begin
        // Hold off once mid-phase until the pipe is empty.
        if (n == RandomWords / 16) settle();
        case ($urandom_range(19))
          0, 1, 2: begin
            tgt = RpmW'($urandom);
            msr = RpmW'($urandom);
          end
          3, 4: begin
            tgt = RpmW'(rpm_corners[$urandom_range(4)]);
            msr = RpmW'(rpm_corners[$urandom_range(4)]);
          end
          default: begin
            if ($urandom_range(31) == 0) begin
              set_rpm = int'($signed(RpmW'($urandom)));
              spread  = 1 << $urandom_range(11);
            end
            meas = set_rpm + int'($urandom_range(2 * spread)) - spread;
            if (meas > 32767) meas = 32767;
            if (meas < -32768) meas = -32768;
            tgt = RpmW'(set_rpm);
            msr = RpmW'(meas);
          end
        endcase
        send_cmd(tgt, msr);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    cmd_if.valid        = 1'b0;
    cmd_if.target_rpm   = '0;
    cmd_if.measured_rpm = '0;
    cur_if.ready        = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = '0;
    cfg_wdata_i         = '0;
    rst_ni              = 1'b0;
    kp_gain    = KpReset;
    ki_gain    = KiReset;
    kd_gain    = KdReset;
    int_limit  = IlimReset;
    out_limit  = OlimReset;
    last_error = '0;
    int_sum    = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_integral_window();
    test_output_clamp();
    test_register_decode();
    test_random_traffic(0, 0);
    test_random_traffic(59, 0);
    test_random_traffic(0, 59);
    test_random_traffic(29, 29);

    settle();
    if (mismatches == 0) $display("speed_pid_current_command_unit: match");
    else $display("speed_pid_current_command_unit: mismatch");
    $finish;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("speed_pid_current_command_unit: mismatch");
    $finish;
  end

endmodule
